@@ design/buffer_fill_pi_rate_controller_unit_assert.svh @@
// Assertion macros used by the rate controller top level.
`ifndef BUFFER_FILL_PI_RATE_CONTROLLER_UNIT_ASSERT_SVH
`define BUFFER_FILL_PI_RATE_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFPI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfpi assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BFPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfpi assertion failed");

`endif

@@ design/bfpi_pkg.sv @@
// Shared types, register codes, reset values and the clamp helper.
package bfpi_pkg;

    typedef enum logic [2:0] {
        REG_TARGET_FILL    = 3'd0,
        REG_UPDATE_INTERVAL = 3'd1,
        REG_PROP_GAIN      = 3'd2,
        REG_INTEG_GAIN     = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_ADJUST_LIMIT   = 3'd5,
        REG_STEP_LIMIT     = 3'd6,
        REG_RATE_LIMIT     = 3'd7
    } t_reg_idx;

    localparam logic [19:0] RST_TARGET_FILL     = 20'd0;
    localparam logic [15:0] RST_UPDATE_INTERVAL = 16'd20;
    localparam logic [15:0] RST_PROP_GAIN       = 16'd500;
    localparam logic [15:0] RST_INTEG_GAIN      = 16'd5;
    localparam logic [19:0] RST_INTEGRAL_LIMIT  = 20'd12000;
    localparam logic [15:0] RST_ADJUST_LIMIT    = 16'd1200;
    localparam logic [15:0] RST_STEP_LIMIT      = 16'd150;
    localparam logic [15:0] RST_RATE_LIMIT      = 16'd20000;

    typedef struct packed {
        logic [19:0] target_fill_frames;
        logic [15:0] update_interval_ms;
        logic [15:0] prop_gain_ppm;
        logic [15:0] integ_gain_ppm;
        logic [19:0] integral_limit;
        logic [15:0] adjust_limit_ppm;
        logic [15:0] step_limit_ppm;
        logic [15:0] rate_limit_ppm;
    } t_cfg;

    // error and clamped integral of one controller step
    typedef struct packed {
        logic               valid;
        logic signed [20:0] err;
        logic signed [21:0] integ;
    } t_step;

    // clamped PI adjustment
    typedef struct packed {
        logic               valid;
        logic signed [16:0] adj;
    } t_adj;

    // symmetric clamp to +-lim
    function automatic logic signed [39:0] f_clamp(
        input logic signed [39:0] v,
        input logic [19:0]        lim
    );
        logic signed [39:0] l;
        l = $signed({20'd0, lim});
        if (v > l) begin
            return l;
        end else if (v < -l) begin
            return -l;
        end
        return v;
    endfunction

endpackage

@@ design/bfpi_regs.sv @@
// APB-style configuration register file.
module bfpi_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output bfpi_pkg::t_cfg    o_cfg
);

    bfpi_pkg::t_cfg   r_cfg;
    bfpi_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = bfpi_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_fill_frames <= bfpi_pkg::RST_TARGET_FILL;
            r_cfg.update_interval_ms <= bfpi_pkg::RST_UPDATE_INTERVAL;
            r_cfg.prop_gain_ppm      <= bfpi_pkg::RST_PROP_GAIN;
            r_cfg.integ_gain_ppm     <= bfpi_pkg::RST_INTEG_GAIN;
            r_cfg.integral_limit     <= bfpi_pkg::RST_INTEGRAL_LIMIT;
            r_cfg.adjust_limit_ppm   <= bfpi_pkg::RST_ADJUST_LIMIT;
            r_cfg.step_limit_ppm     <= bfpi_pkg::RST_STEP_LIMIT;
            r_cfg.rate_limit_ppm     <= bfpi_pkg::RST_RATE_LIMIT;
        end else if (w_wr) begin
            case (w_idx)
                bfpi_pkg::REG_TARGET_FILL:     r_cfg.target_fill_frames <= pwdata[19:0];
                bfpi_pkg::REG_UPDATE_INTERVAL: r_cfg.update_interval_ms <= pwdata[15:0];
                bfpi_pkg::REG_PROP_GAIN:       r_cfg.prop_gain_ppm      <= pwdata[15:0];
                bfpi_pkg::REG_INTEG_GAIN:      r_cfg.integ_gain_ppm     <= pwdata[15:0];
                bfpi_pkg::REG_INTEGRAL_LIMIT:  r_cfg.integral_limit     <= pwdata[19:0];
                bfpi_pkg::REG_ADJUST_LIMIT:    r_cfg.adjust_limit_ppm   <= pwdata[15:0];
                bfpi_pkg::REG_STEP_LIMIT:      r_cfg.step_limit_ppm     <= pwdata[15:0];
                bfpi_pkg::REG_RATE_LIMIT:      r_cfg.rate_limit_ppm     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            bfpi_pkg::REG_TARGET_FILL:     prdata = {12'd0, r_cfg.target_fill_frames};
            bfpi_pkg::REG_UPDATE_INTERVAL: prdata = {16'd0, r_cfg.update_interval_ms};
            bfpi_pkg::REG_PROP_GAIN:       prdata = {16'd0, r_cfg.prop_gain_ppm};
            bfpi_pkg::REG_INTEG_GAIN:      prdata = {16'd0, r_cfg.integ_gain_ppm};
            bfpi_pkg::REG_INTEGRAL_LIMIT:  prdata = {12'd0, r_cfg.integral_limit};
            bfpi_pkg::REG_ADJUST_LIMIT:    prdata = {16'd0, r_cfg.adjust_limit_ppm};
            bfpi_pkg::REG_STEP_LIMIT:      prdata = {16'd0, r_cfg.step_limit_ppm};
            bfpi_pkg::REG_RATE_LIMIT:      prdata = {16'd0, r_cfg.rate_limit_ppm};
            default:                       prdata = 32'd0;
        endcase
    end

endmodule

@@ design/bfpi_integ.sv @@
// Step gating on the update interval, error and clamped integral.
module bfpi_integ (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  logic [19:0]          i_fill,
    input  logic [31:0]          i_time,
    input  bfpi_pkg::t_cfg       i_cfg,
    output bfpi_pkg::t_step      o_step
);

    logic [31:0]        r_last_time;
    logic               r_has_stepped;
    logic signed [21:0] r_integ;
    bfpi_pkg::t_step    r_step;

    logic [31:0]        w_elapsed;
    logic               w_go;
    logic signed [20:0] w_err;
    logic signed [22:0] w_sum;
    logic signed [39:0] w_clamped;

    // elapsed time wraps mod 2^32
    assign w_elapsed = i_time - r_last_time;
    assign w_go      = i_valid &&
                       (!r_has_stepped || (w_elapsed >= {16'd0, i_cfg.update_interval_ms}));
    assign w_err     = $signed({1'b0, i_fill}) - $signed({1'b0, i_cfg.target_fill_frames});
    assign w_sum     = $signed({r_integ[21], r_integ}) + $signed({{2{w_err[20]}}, w_err});
    assign w_clamped = bfpi_pkg::f_clamp($signed({{17{w_sum[22]}}, w_sum}),
                                         i_cfg.integral_limit);
    assign o_step    = r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time   <= 32'd0;
            r_has_stepped <= 1'b0;
            r_integ       <= 22'sd0;
            r_step.valid  <= 1'b0;
        end else if (i_adv) begin
            r_step.valid <= w_go;
            r_step.err   <= w_err;
            r_step.integ <= w_clamped[21:0];
            if (w_go) begin
                r_last_time   <= i_time;
                r_has_stepped <= 1'b1;
                r_integ       <= w_clamped[21:0];
            end
        end
    end

endmodule

@@ design/bfpi_gain.sv @@
// Proportional and integral products, then the clamped adjustment.
module bfpi_gain (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  bfpi_pkg::t_step  i_step,
    input  bfpi_pkg::t_cfg   i_cfg,
    output bfpi_pkg::t_adj   o_adj
);

    logic               r_prod_valid;
    logic signed [37:0] r_prod_p;
    logic signed [38:0] r_prod_i;
    bfpi_pkg::t_adj     r_adj;

    logic signed [37:0] w_prod_p;
    logic signed [38:0] w_prod_i;
    logic signed [39:0] w_sum;
    logic signed [39:0] w_clamped;

    assign w_prod_p  = $signed({1'b0, i_cfg.prop_gain_ppm}) * i_step.err;
    assign w_prod_i  = $signed({1'b0, i_cfg.integ_gain_ppm}) * i_step.integ;
    assign w_sum     = $signed({{2{r_prod_p[37]}}, r_prod_p}) +
                       $signed({r_prod_i[38], r_prod_i});
    assign w_clamped = bfpi_pkg::f_clamp(w_sum, {4'd0, i_cfg.adjust_limit_ppm});
    assign o_adj     = r_adj;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
            r_adj.valid  <= 1'b0;
        end else if (i_adv) begin
            r_prod_valid <= i_step.valid;
            r_prod_p     <= w_prod_p;
            r_prod_i     <= w_prod_i;
            r_adj.valid  <= r_prod_valid;
            r_adj.adj    <= w_clamped[16:0];
        end
    end

endmodule

@@ design/bfpi_slew.sv @@
// Slew limit, hard clamp, change test and the result register.
module bfpi_slew (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  bfpi_pkg::t_adj     i_adj,
    input  bfpi_pkg::t_cfg     i_cfg,
    output logic               o_valid,
    output logic signed [16:0] o_rate
);

    logic signed [17:0] r_last;
    logic               r_valid;
    logic signed [16:0] r_rate;

    logic signed [39:0] w_last;
    logic signed [39:0] w_delta;
    logic signed [39:0] w_cmd;
    logic signed [39:0] w_diff;
    logic               w_move;

    assign w_last  = $signed({{22{r_last[17]}}, r_last});
    assign w_delta = bfpi_pkg::f_clamp($signed({{23{i_adj.adj[16]}}, i_adj.adj}) - w_last,
                                       {4'd0, i_cfg.step_limit_ppm});
    // hard clamp comes last and wins over the slew limit
    assign w_cmd   = bfpi_pkg::f_clamp(w_last + w_delta, {4'd0, i_cfg.rate_limit_ppm});
    assign w_diff  = w_cmd - w_last;
    assign w_move  = i_adj.valid && ((w_diff > 40'sd1) || (w_diff < -40'sd1));
    assign o_valid = r_valid;
    assign o_rate  = r_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_last  <= 18'sd0;
        end else if (i_adv) begin
            r_valid <= w_move;
            if (w_move) begin
                r_last <= w_cmd[17:0];
                r_rate <= w_cmd[16:0];
            end
        end
    end

endmodule

@@ design/buffer_fill_pi_rate_controller_unit.sv @@
// Buffer-fill PI rate controller: input register, three compute stages, result register.
// A request that causes a result passes the input, integ, product and adjustment registers before o_out_valid.
// Throughput: one request per cycle; the whole pipeline advances together and holds
// only while the result register is full and not taken.
// Requests too early for a step, or whose command moves by at most 1 ppm, give no result.
// Reset (i_rst_n low, synchronous) loads register defaults and clears the valid flags and controller loop state.
module buffer_fill_pi_rate_controller_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // measurement requests
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [19:0]        i_queued_frames,
    input  logic [31:0]        i_time_ms,
    // rate command results
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [16:0] o_rate_offset_ppm,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    bfpi_pkg::t_cfg  w_cfg;
    bfpi_pkg::t_step w_step;
    bfpi_pkg::t_adj  w_adj;
    logic            w_adv;

    // input register
    logic            r_in_valid;
    logic [19:0]     r_in_fill;
    logic [31:0]     r_in_time;

    // Every stage moves when the result slot is empty or being drained. A request
    // that leaves no result just flows through as a bubble.
    assign w_adv      = !o_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_adv) begin
            r_in_valid <= i_in_valid;
            r_in_fill  <= i_queued_frames;
            r_in_time  <= i_time_ms;
        end
    end

    bfpi_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // interval gate, error, integral (integral and step time loops close through their own registers)
    bfpi_integ u_integ (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_in_valid),
        .i_fill  (r_in_fill),
        .i_time  (r_in_time),
        .i_cfg   (w_cfg),
        .o_step  (w_step)
    );

    // two registered products, then sum and adjustment clamp
    bfpi_gain u_gain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_step  (w_step),
        .i_cfg   (w_cfg),
        .o_adj   (w_adj)
    );

    // slew against the last command; last command loop closes here
    bfpi_slew u_slew (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_adj   (w_adj),
        .i_cfg   (w_cfg),
        .o_valid (o_out_valid),
        .o_rate  (o_rate_offset_ppm)
    );

`include "buffer_fill_pi_rate_controller_unit_assert.svh"

    // a stalled result freezes the input side
    `BFPI_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready)
    // a new result comes only from a valid adjustment stage
    `BFPI_ASSERT_NOW(a_result_source, i_clk, i_rst_n, $rose(o_out_valid), $past(w_adj.valid))
    // the command never exceeds the hard clamp
    `BFPI_ASSERT_NOW(a_rate_in_limit, i_clk, i_rst_n, o_out_valid, (o_rate_offset_ppm <= $signed({1'b0, w_cfg.rate_limit_ppm})) && (o_rate_offset_ppm >= -$signed({1'b0, w_cfg.rate_limit_ppm})))

endmodule
